[sv/top3js_pkg.sv]
package top3js_pkg;

  // Signed Q5.10 tag score.
  typedef logic signed [15:0] score_t;

  // Attributes of one jet as it is ranked, score in the top bits.
  typedef struct packed {
    score_t             score;
    logic signed [7:0]  flavour;
    logic [3:0]         c_count;
    logic [3:0]         b_count;
  } jet_t;

  // The third-ranked slot as seen after the current jet is ranked.
  typedef struct packed {
    logic       valid;
    jet_t       jet;
    logic [4:0] index;
  } third_t;

  // Jet categories reported for the third-ranked jet.
  typedef enum logic [3:0] {
    CAT_NONE    = 4'd0,
    CAT_2B      = 4'd1,
    CAT_1B      = 4'd2,
    CAT_2C      = 4'd3,
    CAT_1C      = 4'd4,
    CAT_LIGHT   = 4'd5,
    CAT_GLUON   = 4'd6,
    CAT_PILEUP  = 4'd7,
    CAT_UNCLASS = 4'd8
  } category_t;

  // Width of the reported jet index.
  localparam int INDEX_W = 5;

  // Floor reset value, -30.0 in Q5.10.
  localparam score_t FLOOR_RESET = 16'sh8800;

  // Parton flavour code of a gluon; light quarks lie strictly inside +/- this value.
  localparam logic signed [7:0] GLUON_CODE = 8'sd21;

  // Register index of score_floor, taken from byte address bit 2.
  localparam logic REG_SCORE_FLOOR = 1'b0;

endpackage

[sv/top3_jet_select_classify_unit.sv]
// The item that closes the event passes the input register, then the result register,
// to reach the master side. Throughput: one jet per cycle; the three-slot compare and
// shift is the path that sets the figure. A full result register stalls an item that
// closes an event, and the items queued behind it.
// Reset (synchronous, active high) empties the slots, zeroes the jet counter,
// drops both valid flags and sets score_floor to -30.0.
module top3_jet_select_classify_unit #(
  parameter int MAX_JETS = 32
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Jet input.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // tag_score[15:0], b_hadron_count[19:16],
                                // c_hadron_count[23:20], flavour_code[31:24]
  input  logic        s_tuser,  // jet_present
  input  logic        s_tlast,  // last_jet
  // Result output.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata   // category[3:0], third_index[8:4],
                                // third_score[24:9], zero above
);

  top3js_pkg::score_t score_floor;
  top3js_pkg::jet_t   in_jet;
  logic               in_valid;
  logic               in_present;
  logic               in_last;
  logic               out_free;
  logic               advance;
  top3js_pkg::third_t third;
  logic [3:0]         category;
  logic [4:0]         third_index;
  top3js_pkg::score_t third_score;

  // Configuration register.
  assign pready = 1'b1;
  assign prdata = {{16{score_floor[15]}}, score_floor};

  always_ff @(posedge clk) begin
    if (rst) begin
      score_floor <= top3js_pkg::FLOOR_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == top3js_pkg::REG_SCORE_FLOOR) begin
      score_floor <= pwdata[15:0];
    end
  end

  // Input register; an item moves on unless it closes an event and the result is held.
  assign out_free = !m_tvalid || m_tready;
  assign advance  = in_valid && (!in_last || out_free);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_jet.score   <= s_tdata[15:0];
      in_jet.b_count <= s_tdata[19:16];
      in_jet.c_count <= s_tdata[23:20];
      in_jet.flavour <= s_tdata[31:24];
      in_present     <= s_tuser;
      in_last        <= s_tlast;
    end
  end

  top3js_rank #(
    .MAX_JETS(MAX_JETS)
  ) u_rank (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .present (in_present),
    .last    (in_last),
    .jet     (in_jet),
    .floor   (score_floor),
    .third   (third)
  );

  top3js_out u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && in_last),
    .take     (m_tready),
    .third    (third),
    .floor    (score_floor),
    .valid    (m_tvalid),
    .category (category),
    .index    (third_index),
    .score    (third_score)
  );

  assign m_tdata = {7'd0, third_score, third_index, category};

  // A result always leaves reset empty.
  a_reset_empty : assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // No third jet means index zero.
  a_none_index : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[3:0] == top3js_pkg::CAT_NONE |-> m_tdata[8:4] == 5'd0)
    else $error("empty category with nonzero index");

  // Category stays within the defined codes.
  a_cat_range : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[3:0] <= top3js_pkg::CAT_UNCLASS)
    else $error("category code out of range");

  // A result is loaded only into a free result register.
  a_no_overwrite : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("held result overwritten");

endmodule

[sv/top3js_rank.sv]
module top3js_rank #(
  parameter int MAX_JETS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic                present,
  input  logic                last,
  input  top3js_pkg::jet_t    jet,
  input  top3js_pkg::score_t  floor,
  output top3js_pkg::third_t  third
);

  localparam int CNT_W = $clog2(MAX_JETS);
  localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(MAX_JETS - 1);
  localparam int INDEX_W_PAD = top3js_pkg::INDEX_W;

  top3js_pkg::jet_t  slot_jet [3];
  logic [CNT_W-1:0]  slot_pos [3];
  logic [2:0]        slot_valid;
  logic [CNT_W-1:0]  jet_counter;

  top3js_pkg::jet_t  slot_jet_next [3];
  logic [CNT_W-1:0]  slot_pos_next [3];
  logic [2:0]        slot_valid_next;
  logic [CNT_W-1:0]  jet_counter_next;

  logic signed [15:0]      cmp_value [3];
  logic [CNT_W+INDEX_W_PAD-1:0] pos_wide;

  // An empty slot always compares as the live floor.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cmp_value[k] = slot_valid[k] ? $signed(slot_jet[k].score) : $signed(floor);
    end
  end

  // Insert the jet and shift the lower slots down; ties keep the earlier jet.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      slot_jet_next[k] = slot_jet[k];
      slot_pos_next[k] = slot_pos[k];
    end
    slot_valid_next = slot_valid;
    jet_counter_next = jet_counter;
    if (present) begin
      priority if ($signed(jet.score) > cmp_value[0]) begin
        slot_jet_next[2]   = slot_jet[1];
        slot_pos_next[2]   = slot_pos[1];
        slot_valid_next[2] = slot_valid[1];
        slot_jet_next[1]   = slot_jet[0];
        slot_pos_next[1]   = slot_pos[0];
        slot_valid_next[1] = slot_valid[0];
        slot_jet_next[0]   = jet;
        slot_pos_next[0]   = jet_counter;
        slot_valid_next[0] = 1'b1;
      end else if ($signed(jet.score) > cmp_value[1]) begin
        slot_jet_next[2]   = slot_jet[1];
        slot_pos_next[2]   = slot_pos[1];
        slot_valid_next[2] = slot_valid[1];
        slot_jet_next[1]   = jet;
        slot_pos_next[1]   = jet_counter;
        slot_valid_next[1] = 1'b1;
      end else if ($signed(jet.score) > cmp_value[2]) begin
        slot_jet_next[2]   = jet;
        slot_pos_next[2]   = jet_counter;
        slot_valid_next[2] = 1'b1;
      end else begin
        // A jet at or below the third slot is not ranked.
        slot_valid_next = slot_valid;
      end
      if (jet_counter != CNT_TOP) begin
        jet_counter_next = jet_counter + CNT_W'(1);
      end
    end
  end

  // The reported index keeps the low bits of the slot position.
  assign pos_wide = {{INDEX_W_PAD{1'b0}}, slot_pos_next[2]};

  always_comb begin
    third.valid = slot_valid_next[2];
    third.jet   = slot_jet_next[2];
    third.index = pos_wide[INDEX_W_PAD-1:0];
  end

  // Slot occupancy and the jet counter; both clear at the end of an event.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid  <= '0;
      jet_counter <= '0;
    end else if (step) begin
      if (last) begin
        slot_valid  <= '0;
        jet_counter <= '0;
      end else begin
        slot_valid  <= slot_valid_next;
        jet_counter <= jet_counter_next;
      end
    end
  end

  // Slot contents are only read while the slot is valid.
  always_ff @(posedge clk) begin
    if (step) begin
      for (int k = 0; k < 3; k++) begin
        slot_jet[k] <= slot_jet_next[k];
        slot_pos[k] <= slot_pos_next[k];
      end
    end
  end

endmodule

[sv/top3js_out.sv]
module top3js_out (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  logic                take,
  input  top3js_pkg::third_t  third,
  input  top3js_pkg::score_t  floor,
  output logic                valid,
  output logic [3:0]          category,
  output logic [4:0]          index,
  output top3js_pkg::score_t  score
);

  top3js_pkg::category_t cat_next;
  logic [3:0]            b_cnt;
  logic [3:0]            c_cnt;
  logic signed [7:0]     flav;

  assign b_cnt = third.jet.b_count;
  assign c_cnt = third.jet.c_count;
  assign flav  = third.jet.flavour;

  // Classify the third jet; the first rule that holds wins.
  always_comb begin
    priority if (!third.valid) begin
      cat_next = top3js_pkg::CAT_NONE;
    end else if (b_cnt >= 4'd2) begin
      cat_next = top3js_pkg::CAT_2B;
    end else if (b_cnt == 4'd1) begin
      cat_next = top3js_pkg::CAT_1B;
    end else if (c_cnt >= 4'd2) begin
      cat_next = top3js_pkg::CAT_2C;
    end else if (c_cnt == 4'd1) begin
      cat_next = top3js_pkg::CAT_1C;
    end else if (flav != 8'sd0 && flav < top3js_pkg::GLUON_CODE &&
                 flav > -top3js_pkg::GLUON_CODE) begin
      cat_next = top3js_pkg::CAT_LIGHT;
    end else if (flav == top3js_pkg::GLUON_CODE) begin
      cat_next = top3js_pkg::CAT_GLUON;
    end else if (flav == 8'sd0) begin
      cat_next = top3js_pkg::CAT_PILEUP;
    end else begin
      cat_next = top3js_pkg::CAT_UNCLASS;
    end
  end

  // Result valid flag: set on load, cleared once the result is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  // Result payload; an empty third slot reports index zero and the floor.
  always_ff @(posedge clk) begin
    if (load) begin
      category <= cat_next;
      index    <= third.valid ? third.index : '0;
      score    <= third.valid ? third.jet.score : floor;
    end
  end

endmodule

[bench/top3_jet_select_classify_unit_tb.sv]
`timescale 1ns / 100ps

module top3_jet_select_classify_unit_tb;

  localparam int MAX_JETS = 32;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_JETS = 160;
  localparam int HOLD_AFTER = 400;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 4;

  // One reported result: category, index and score of the third-ranked jet.
  typedef struct packed {
    top3js_pkg::category_t cat;
    logic [4:0]            idx;
    top3js_pkg::score_t    score;
  } result_t;

  // One input item, with a typed-in result where it is obvious.
  typedef struct {
    top3js_pkg::jet_t jet;
    bit               present;
    bit               last;
    bit               typed;
    result_t          want;
  } row_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;  // tag_score[15:0], b_hadron_count[19:16],
                         // c_hadron_count[23:20], flavour_code[31:24]
  logic        s_tuser;  // jet_present
  logic        s_tlast;  // last_jet
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;  // category[3:0], third_index[8:4], third_score[24:9]

  // Shadow of the ranking state and of the floor register.
  top3js_pkg::score_t floor_q = top3js_pkg::FLOOR_RESET;
  top3js_pkg::third_t slots[3] = '{default: '0};
  logic [4:0]         jet_cnt = '0;

  result_t     expected_thirds[$];
  row_t        dir_rows[$];
  int unsigned jets_taken = 0;
  int unsigned mismatches = 0;
  int          burst_left = 0;
  int          ev_left = 0;
  bit          ev_empty = 0;

  top3_jet_select_classify_unit #(
    .MAX_JETS(MAX_JETS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Append one row to the directed table.
  task automatic add_row(input row_t r);
    dir_rows.insert(dir_rows.size(), r);
  endtask

  // Append one expected result to the scoreboard.
  task automatic queue_result(input result_t res);
    expected_thirds.insert(expected_thirds.size(), res);
  endtask

  // An empty slot always compares as the live floor value.
  function automatic top3js_pkg::score_t slot_level(input int k);
    return slots[k].valid ? slots[k].jet.score : floor_q;
  endfunction

  function automatic top3js_pkg::category_t jet_category(input top3js_pkg::jet_t j);
    int fl;
    fl = $signed(j.flavour);
    if (j.b_count >= 2) return top3js_pkg::CAT_2B;
    if (j.b_count == 1) return top3js_pkg::CAT_1B;
    if (j.c_count >= 2) return top3js_pkg::CAT_2C;
    if (j.c_count == 1) return top3js_pkg::CAT_1C;
    if (fl != 0 && fl > -top3js_pkg::GLUON_CODE && fl < top3js_pkg::GLUON_CODE)
      return top3js_pkg::CAT_LIGHT;
    if (fl == top3js_pkg::GLUON_CODE) return top3js_pkg::CAT_GLUON;
    if (fl == 0) return top3js_pkg::CAT_PILEUP;
    return top3js_pkg::CAT_UNCLASS;
  endfunction

  // Rank one accepted item into the top three and close the event on last_jet.
  task automatic rank_jet(input row_t r, output bit emits, output result_t res);
    top3js_pkg::third_t fresh;
    fresh.valid = 1'b1;
    fresh.jet = r.jet;
    fresh.index = jet_cnt;
    emits = 1'b0;
    res = '0;
    if (r.present) begin
      if ($signed(r.jet.score) > $signed(slot_level(0))) begin
        slots[2] = slots[1];
        slots[1] = slots[0];
        slots[0] = fresh;
      end else if ($signed(r.jet.score) > $signed(slot_level(1))) begin
        slots[2] = slots[1];
        slots[1] = fresh;
      end else if ($signed(r.jet.score) > $signed(slot_level(2))) begin
        slots[2] = fresh;
      end
      if (jet_cnt < MAX_JETS - 1) jet_cnt++;
    end
    if (r.last) begin
      emits = 1'b1;
      if (slots[2].valid) begin
        res.cat = jet_category(slots[2].jet);
        res.idx = slots[2].index;
        res.score = slots[2].jet.score;
      end else begin
        res.cat = top3js_pkg::CAT_NONE;
        res.idx = '0;
        res.score = floor_q;
      end
      foreach (slots[k]) slots[k] = '0;
      jet_cnt = '0;
    end
  endtask

  function automatic row_t jet_row(input int s, input int b, input int c, input int f,
                                   input bit present, input bit last, input bit typed = 0,
                                   input top3js_pkg::category_t cat = top3js_pkg::CAT_NONE,
                                   input int idx = 0, input int want_score = 0);
    row_t r;
    r.jet.score = 16'(s);
    r.jet.b_count = 4'(b);
    r.jet.c_count = 4'(c);
    r.jet.flavour = 8'(f);
    r.present = present;
    r.last = last;
    r.typed = typed;
    r.want.cat = cat;
    r.want.idx = 5'(idx);
    r.want.score = 16'(want_score);
    return r;
  endfunction

  // Draw the next item of a random event; events are mostly well formed.
  task automatic random_row(output row_t r);
    int s;
    int b;
    int c;
    int f;
    int k;
    if (ev_left == 0) begin
      k = $urandom_range(0, 99);
      ev_empty = (k < 8);
      if (k < 8) ev_left = 1;
      else if (k < 14) ev_left = $urandom_range(30, 40);
      else ev_left = $urandom_range(1, 8);
    end
    case ($urandom_range(0, 3))
      0: s = $urandom_range(0, 16'hffff);
      1: s = int'(floor_q) + $urandom_range(0, 4) - 2;
      2: s = $urandom_range(0, 3) * 256 - 256;
      default: s = $urandom_range(0, 8192) - 4096;
    endcase
    k = $urandom_range(0, 7);
    b = (k == 0) ? $urandom_range(0, 15) : (k == 1) ? 1 : (k == 2) ? 2 : 0;
    k = $urandom_range(0, 7);
    c = (k == 0) ? $urandom_range(0, 15) : (k == 1) ? 1 : (k == 2) ? 2 : 0;
    case ($urandom_range(0, 5))
      0: f = 0;
      1: f = top3js_pkg::GLUON_CODE;
      2: f = $urandom_range(0, 1) ? $urandom_range(1, 20) : -$urandom_range(1, 20);
      3: begin
        k = $urandom_range(0, 5);
        f = (k == 0) ? -21 : (k == 1) ? 22 : (k == 2) ? -128 : (k == 3) ? 127 :
            (k == 4) ? 20 : -20;
      end
      default: f = $urandom_range(0, 255);
    endcase
    // Now and then an item with no jet that does not close the event.
    if ($urandom_range(0, 11) == 0) begin
      r = jet_row(s, b, c, f, 1'b0, 1'b0);
    end else if (ev_left == 1) begin
      r = jet_row(s, b, c, f, !ev_empty && ($urandom_range(0, 7) != 0), 1'b1);
      ev_left = 0;
    end else begin
      r = jet_row(s, b, c, f, 1'b1, 1'b0);
      ev_left--;
    end
  endtask

  // Offer one item in bursts with random gaps; predict once the transfer happens.
  task automatic send_row(input row_t r);
    bit      emits;
    result_t res;
    int      gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= {r.jet.flavour, r.jet.c_count, r.jet.b_count, r.jet.score};
    s_tuser <= r.present;
    s_tlast <= r.last;
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
    jets_taken++;
    rank_jet(r, emits, res);
    if (r.typed) queue_result(r.want);
    else if (emits) queue_result(res);
  endtask

  // Register write through the APB port, once the block has drained, then a read back.
  task automatic write_floor(input top3js_pkg::score_t v);
    s_tvalid <= 1'b0;
    while (expected_thirds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {top3js_pkg::REG_SCORE_FLOOR, 2'b00};
    pwdata <= {{16{v[15]}}, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (!pready || prdata !== {{16{v[15]}}, v}) begin
      if (mismatches < 10)
        $display("%0t: floor read back %0h, expected %0h",
                 $time, prdata, {{16{v[15]}}, v});
      mismatches++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    floor_q = v;
  endtask

  initial begin : stimulus
    row_t               r;
    top3js_pkg::score_t floor_plan[5];
    int                 taken;
    bit                 close_evt;

    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    s_tlast = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // An empty event right after reset reports the reset floor.
    add_row(jet_row(0, 0, 0, 0, 0, 1, 1, top3js_pkg::CAT_NONE, 0, top3js_pkg::FLOOR_RESET));
    // An item with no jet and no end changes nothing.
    add_row(jet_row(32767, 15, 15, -1, 0, 0));
    // Top score twice (the tie keeps the earlier jet), the bottom score and a score
    // equal to the floor are not ranked, and a score just above the floor comes third.
    add_row(jet_row(32767, 15, 0, 0, 1, 0));
    add_row(jet_row(32767, 0, 15, 127, 1, 0));
    add_row(jet_row(-32768, 1, 0, -128, 1, 0));
    add_row(jet_row(-30720, 2, 0, 0, 1, 0));
    add_row(jet_row(-30719, 0, 1, 5, 1, 1, 1, top3js_pkg::CAT_1C, 4, -30719));
    // One event each for 2B, 1B, 2C, light, gluon and pileup, the third jet arriving last.
    add_row(jet_row(3000, 0, 0, 21, 1, 0));
    add_row(jet_row(2000, 1, 1, 0, 1, 0));
    add_row(jet_row(1000, 2, 15, -1, 1, 1, 1, top3js_pkg::CAT_2B, 2, 1000));
    add_row(jet_row(3000, 0, 2, 1, 1, 0));
    add_row(jet_row(2000, 0, 0, 0, 1, 0));
    add_row(jet_row(1000, 1, 15, 21, 1, 1, 1, top3js_pkg::CAT_1B, 2, 1000));
    add_row(jet_row(3000, 1, 0, 0, 1, 0));
    add_row(jet_row(2000, 0, 0, 0, 1, 0));
    add_row(jet_row(1000, 0, 2, -128, 1, 1, 1, top3js_pkg::CAT_2C, 2, 1000));
    add_row(jet_row(3000, 0, 0, 0, 1, 0));
    add_row(jet_row(2000, 2, 0, 0, 1, 0));
    add_row(jet_row(1000, 0, 0, -20, 1, 1, 1, top3js_pkg::CAT_LIGHT, 2, 1000));
    add_row(jet_row(3000, 0, 0, 0, 1, 0));
    add_row(jet_row(2000, 0, 0, 0, 1, 0));
    add_row(jet_row(1000, 0, 0, 21, 1, 1, 1, top3js_pkg::CAT_GLUON, 2, 1000));
    add_row(jet_row(3000, 0, 0, 21, 1, 0));
    add_row(jet_row(2000, 0, 0, 21, 1, 0));
    add_row(jet_row(1000, 0, 0, 0, 1, 1, 1, top3js_pkg::CAT_PILEUP, 2, 1000));
    // The third jet arrives first here, so the result comes from the predictor.
    add_row(jet_row(1000, 0, 0, -128, 1, 0));
    add_row(jet_row(3000, 0, 0, 0, 1, 0));
    add_row(jet_row(2000, 0, 0, 0, 1, 1));
    foreach (dir_rows[i]) send_row(dir_rows[i]);

    // Random phases, each after the first under a newly written floor; a phase may stop in mid-event.
    floor_plan[0] = 16'sh8000;
    floor_plan[1] = 16'sh0000;
    floor_plan[2] = 16'sh7fff;
    floor_plan[3] = 16'($urandom_range(0, 8192) - 4096);
    floor_plan[4] = top3js_pkg::FLOOR_RESET;
    for (int p = 0; p < 6; p++) begin
      if (p > 0) write_floor(floor_plan[p - 1]);
      close_evt = (p == 5) || ($urandom_range(0, 1) == 0);
      taken = 0;
      while (taken < PHASE_JETS || (close_evt && ev_left != 0)) begin
        random_row(r);
        send_row(r);
        if (r.present || r.last) taken++;
      end
    end

    s_tvalid <= 1'b0;
    while (expected_thirds.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Receiver: rotating ready patterns, plus one long hold-off so the block backs up.
  initial begin : receiver
    logic [15:0] ready_pat;
    int          pat_left;
    bit          held;
    ready_pat = '1;
    pat_left = 0;
    held = 1'b0;
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && jets_taken >= HOLD_AFTER) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (pat_left == 0) begin
        pat_left = $urandom_range(32, 160);
        case ($urandom_range(0, 3))
          0: ready_pat = '1;
          1: ready_pat = 16'($urandom);
          2: ready_pat = 16'($urandom) | 16'($urandom);
          default: ready_pat = 16'($urandom) & 16'($urandom);
        endcase
        if (ready_pat == '0) ready_pat = 16'h0001;
      end
      pat_left--;
      m_tready <= ready_pat[0];
      ready_pat = {ready_pat[0], ready_pat[15:1]};
    end
  end

  // Compare each result transfer with the oldest expectation.
  always @(negedge clk) begin : result_check
    result_t            want;
    logic [3:0]         got_cat;
    logic [4:0]         got_idx;
    top3js_pkg::score_t got_score;
    if (!rst && m_tvalid && m_tready) begin
      got_cat = m_tdata[3:0];
      got_idx = m_tdata[8:4];
      got_score = m_tdata[24:9];
      if (expected_thirds.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: result with none expected: category %0d index %0d score %0d",
                   $time, got_cat, got_idx, got_score);
        mismatches++;
      end else begin
        want = expected_thirds.pop_front();
        if (got_cat !== want.cat || got_idx !== want.idx || got_score !== want.score ||
            m_tdata[31:25] !== '0) begin
          if (mismatches < 10) begin
            $write("%0t: expected category %0d index %0d score %0d, ",
                   $time, want.cat, want.idx, want.score);
            $display("got category %0d index %0d score %0d pad %0h",
                     got_cat, got_idx, got_score, m_tdata[31:25]);
          end
          mismatches++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

endmodule

[filelist.f]
sv/top3js_pkg.sv
sv/top3js_rank.sv
sv/top3js_out.sv
sv/top3_jet_select_classify_unit.sv
bench/top3_jet_select_classify_unit_tb.sv
